// ----- hdl/wdss_pkg.sv -----
// ----------------------------------------------------------------------------
// wdss_pkg
// Shared types, codes and constants of the windowed delta sensitivity selector.
// ----------------------------------------------------------------------------
package wdss_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int LEN_W          = 5;
  localparam int CNT_W          = 5;
  localparam int SUM_W          = SAMPLE_W + LEN_W;
  localparam int LEVEL_W        = 2;
  localparam int WINDOW_MAX_DEF = 16;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  localparam logic [SAMPLE_W-1:0] LOW_RESET  = 16'h0000;
  localparam logic [SAMPLE_W-1:0] HIGH_RESET = 16'hFFFF;
  localparam logic [LEN_W-1:0]    LEN_RESET  = 5'd4;

  localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_ACUTE  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_OBTUSE = 2'd2;

  localparam logic [1:0] HAND_OUT = 2'd0;
  localparam logic [1:0] HAND_IN  = 2'd1;

  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_LEN  = 2'd2;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_COND,
    REQ_ENABLE,
    REQ_DISABLE
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SUM,
    ST_DIV,
    ST_AVG,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_SIMPLE,
    OP_APPEND,
    OP_SHIFT,
    OP_AVERAGE
  } op_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [3:0]          touch_count;
    logic [SAMPLE_W-1:0] peak_delta;
    logic                display_resumed;
    logic                core_active;
    logic                charger_connected;
    logic                wireless_charging;
    logic                call_active;
    logic [1:0]          hand_state;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  sensitivity;
    logic                sensitivity_changed;
    logic                delta_check_on;
    logic                feature_on;
    logic [SAMPLE_W-1:0] average;
    logic                average_valid;
    logic [CNT_W-1:0]    samples_held;
  } result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low;
    logic [SAMPLE_W-1:0] high;
    logic [LEN_W-1:0]    len;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic apply;
    logic shift_read;
    logic shift_write;
    logic shift_last;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic avg_apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic shift_more;
    logic sum_done;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/wdss_if.sv -----
// ----------------------------------------------------------------------------
// wdss_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface wdss_item_if ();
  logic           valid;
  logic           ready;
  wdss_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wdss_result_if ();
  logic             valid;
  logic             ready;
  wdss_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/wdss_cfg.sv -----
// ----------------------------------------------------------------------------
// wdss_cfg
// APB register file: thresholds and window length.
// ----------------------------------------------------------------------------
module wdss_cfg #(
  parameter int WINDOW_MAX = wdss_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wdss_pkg::PADDR_W-1:0] paddr,
  input  logic [wdss_pkg::PDATA_W-1:0] pwdata,
  output logic [wdss_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output wdss_pkg::cfg_t               cfg
);

  logic       wr;
  logic [1:0] reg_idx;
  logic       len_ok;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[wdss_pkg::PADDR_W-1:2];
  assign len_ok  = (pwdata[wdss_pkg::LEN_W-1:0] != '0) &&
                   (int'(pwdata[wdss_pkg::LEN_W-1:0]) <= WINDOW_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low  <= wdss_pkg::LOW_RESET;
      cfg.high <= wdss_pkg::HIGH_RESET;
      cfg.len  <= wdss_pkg::LEN_RESET;
    end else if (wr) begin
      case (reg_idx)
        wdss_pkg::REG_LOW:  cfg.low  <= pwdata[wdss_pkg::SAMPLE_W-1:0];
        wdss_pkg::REG_HIGH: cfg.high <= pwdata[wdss_pkg::SAMPLE_W-1:0];
        wdss_pkg::REG_LEN: begin
          if (len_ok) begin
            cfg.len <= pwdata[wdss_pkg::LEN_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wdss_pkg::REG_LOW:  prdata = wdss_pkg::PDATA_W'(cfg.low);
      wdss_pkg::REG_HIGH: prdata = wdss_pkg::PDATA_W'(cfg.high);
      wdss_pkg::REG_LEN:  prdata = wdss_pkg::PDATA_W'(cfg.len);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- hdl/wdss_ctrl.sv -----
// ----------------------------------------------------------------------------
// wdss_ctrl
// Sequencer: accept, decide, shift or sum and divide where needed, then hand off a result.
// ----------------------------------------------------------------------------
module wdss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  wdss_pkg::stat_t stat,
  output wdss_pkg::cmd_t  cmd
);

  wdss_pkg::state_t state;
  wdss_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wdss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wdss_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = wdss_pkg::ST_DECIDE;
        end
      end
      wdss_pkg::ST_DECIDE: begin
        case (stat.op)
          wdss_pkg::OP_SHIFT:   state_next = wdss_pkg::ST_SHIFT_RD;
          wdss_pkg::OP_AVERAGE: state_next = wdss_pkg::ST_SUM;
          default:              state_next = wdss_pkg::ST_FINISH;
        endcase
      end
      wdss_pkg::ST_SHIFT_RD: begin
        state_next = stat.shift_more ? wdss_pkg::ST_SHIFT_WR : wdss_pkg::ST_FINISH;
      end
      wdss_pkg::ST_SHIFT_WR: state_next = wdss_pkg::ST_SHIFT_RD;
      wdss_pkg::ST_SUM: begin
        if (stat.sum_done) begin
          state_next = wdss_pkg::ST_DIV;
        end
      end
      wdss_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_next = wdss_pkg::ST_AVG;
        end
      end
      wdss_pkg::ST_AVG: state_next = wdss_pkg::ST_FINISH;
      wdss_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          state_next = wdss_pkg::ST_IDLE;
        end
      end
      default: state_next = wdss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      wdss_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.latch  = item_valid;
      end
      wdss_pkg::ST_DECIDE: cmd.apply = 1'b1;
      wdss_pkg::ST_SHIFT_RD: begin
        cmd.shift_read = stat.shift_more;
        cmd.shift_last = ~stat.shift_more;
      end
      wdss_pkg::ST_SHIFT_WR: cmd.shift_write = 1'b1;
      wdss_pkg::ST_SUM: begin
        cmd.sum_step = 1'b1;
        cmd.div_init = stat.sum_done;
      end
      wdss_pkg::ST_DIV:    cmd.div_step  = 1'b1;
      wdss_pkg::ST_AVG:    cmd.avg_apply = 1'b1;
      wdss_pkg::ST_FINISH: cmd.emit      = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- hdl/wdss_dp.sv -----
// ----------------------------------------------------------------------------
// wdss_dp
// Datapath: feature state, sample window memory, summing and a restoring
// divider, result register.
// ----------------------------------------------------------------------------
module wdss_dp #(
  parameter int WINDOW_MAX = wdss_pkg::WINDOW_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  wdss_pkg::cfg_t    cfg,
  input  wdss_pkg::item_t   item_data,
  input  wdss_pkg::cmd_t    cmd,
  output wdss_pkg::stat_t   stat,
  input  logic              result_ready,
  output logic              result_valid,
  output wdss_pkg::result_t result_data
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = (AW + 1 > wdss_pkg::LEN_W) ? AW + 1 : wdss_pkg::LEN_W;

  localparam int SW = wdss_pkg::SAMPLE_W;
  localparam int LW = wdss_pkg::LEN_W;
  localparam int NW = wdss_pkg::SUM_W;

  logic [SW-1:0] mem [WINDOW_MAX];
  logic [SW-1:0] rd_data;

  wdss_pkg::item_t cur;
  logic                         feature;
  logic                         delta;
  logic                         pend;
  logic [wdss_pkg::CNT_W-1:0]   count;
  logic [wdss_pkg::LEVEL_W-1:0] level;
  logic [wdss_pkg::LEVEL_W-1:0] level_before;
  logic [SW-1:0]                avg;
  logic                         avg_valid;
  logic [CW-1:0]                idx;
  logic                         acc_pend;
  logic [NW-1:0]                sum;
  logic [NW-1:0]                quo;
  logic [LW-1:0]                rem;

  logic                         feature_next;
  logic                         delta_next;
  logic                         pend_next;
  logic [wdss_pkg::CNT_W-1:0]   count_next;
  logic [wdss_pkg::LEVEL_W-1:0] level_next;

  logic          len_ok;
  logic          usable;
  logic          room;
  logic          is_tick;
  logic          store;
  logic          flush;
  logic          cond_on;
  wdss_pkg::req_t req;
  wdss_pkg::op_t  op;

  logic [CW-1:0] len_c;
  logic [CW-1:0] idx_inc;
  logic          idx_lt_len;

  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;

  logic [LW:0]   rem_sh;
  logic [LW:0]   rem_sub;
  logic          ge;
  logic [wdss_pkg::LEVEL_W-1:0] avg_level;

  assign req        = wdss_pkg::req_t'(cur.req_type);
  assign len_ok     = (cfg.len != '0) && (int'(cfg.len) <= WINDOW_MAX);
  assign usable     = feature & delta & len_ok;
  assign room       = count < cfg.len;
  assign is_tick    = (req == wdss_pkg::REQ_TICK);
  assign store      = is_tick & usable & (cur.touch_count == 4'd1) & ~pend &
                      cur.display_resumed & cur.core_active;
  assign flush      = is_tick & usable & (cur.touch_count == 4'd0) & pend;
  assign cond_on    = ((req == wdss_pkg::REQ_COND) & feature) |
                      (req == wdss_pkg::REQ_ENABLE);

  always_comb begin
    if (store) begin
      op = room ? wdss_pkg::OP_APPEND : wdss_pkg::OP_SHIFT;
    end else if (flush & ~room) begin
      op = wdss_pkg::OP_AVERAGE;
    end else begin
      op = wdss_pkg::OP_SIMPLE;
    end
  end

  always_comb begin
    feature_next = feature;
    delta_next   = delta;
    pend_next    = pend;
    count_next   = count;
    level_next   = level;
    case (req)
      wdss_pkg::REQ_TICK: begin
        if (store) begin
          pend_next = 1'b1;
          if (room) begin
            count_next = count + 1'b1;
          end
        end else if (flush) begin
          pend_next = 1'b0;
        end
      end
      wdss_pkg::REQ_ENABLE: begin
        delta_next   = 1'b0;
        pend_next    = 1'b0;
        count_next   = '0;
        feature_next = 1'b1;
      end
      wdss_pkg::REQ_DISABLE: begin
        if (feature & cur.core_active) begin
          level_next = wdss_pkg::LVL_NORMAL;
        end
        feature_next = 1'b0;
      end
      default: ;
    endcase
    if (cond_on) begin
      if (cur.charger_connected | cur.wireless_charging | cur.call_active) begin
        delta_next = 1'b0;
        if (cur.core_active) begin
          level_next = wdss_pkg::LVL_NORMAL;
        end
      end else if (cur.hand_state == wdss_pkg::HAND_OUT) begin
        delta_next = 1'b1;
        if (cur.core_active) begin
          level_next = wdss_pkg::LVL_ACUTE;
        end
      end else if (cur.hand_state == wdss_pkg::HAND_IN) begin
        delta_next = 1'b1;
        if (cur.core_active) begin
          level_next = wdss_pkg::LVL_NORMAL;
        end
      end
    end
  end

  assign len_c      = CW'(cfg.len);
  assign idx_inc    = idx + 1'b1;
  assign idx_lt_len = idx < len_c;

  assign stat.op         = op;
  assign stat.shift_more = idx_inc < len_c;
  assign stat.sum_done   = ~idx_lt_len & ~acc_pend;
  assign stat.div_last   = (idx == CW'(NW - 1));
  assign stat.out_free   = ~result_valid | result_ready;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = cur.peak_delta;
    if (cmd.apply & (op == wdss_pkg::OP_APPEND)) begin
      we    = 1'b1;
      waddr = AW'(CW'(count));
    end else if (cmd.shift_write) begin
      we    = 1'b1;
      waddr = idx[AW-1:0];
      wdata = rd_data;
    end else if (cmd.shift_last) begin
      we    = 1'b1;
      waddr = AW'(len_c - 1'b1);
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (cmd.shift_read) begin
      re    = 1'b1;
      raddr = idx_inc[AW-1:0];
    end else if (cmd.sum_step & idx_lt_len) begin
      re    = 1'b1;
      raddr = idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  assign rem_sh  = {rem, quo[NW-1]};
  assign ge      = rem_sh >= {1'b0, cfg.len};
  assign rem_sub = rem_sh - {1'b0, cfg.len};

  always_comb begin
    if (quo[SW-1:0] < cfg.low) begin
      avg_level = wdss_pkg::LVL_ACUTE;
    end else if (quo[SW-1:0] > cfg.high) begin
      avg_level = wdss_pkg::LVL_OBTUSE;
    end else begin
      avg_level = wdss_pkg::LVL_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feature  <= 1'b0;
      delta    <= 1'b0;
      pend     <= 1'b0;
      count    <= '0;
      level    <= wdss_pkg::LVL_NORMAL;
      acc_pend <= 1'b0;
    end else begin
      if (cmd.apply) begin
        feature <= feature_next;
        delta   <= delta_next;
        pend    <= pend_next;
        count   <= count_next;
        level   <= level_next;
        if (op == wdss_pkg::OP_AVERAGE) begin
          acc_pend <= 1'b0;
        end
      end
      if (cmd.sum_step) begin
        acc_pend <= idx_lt_len;
      end
      if (cmd.avg_apply & feature & cur.core_active) begin
        level <= avg_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur          <= item_data;
      level_before <= level;
      avg          <= '0;
      avg_valid    <= 1'b0;
    end
    if (cmd.apply) begin
      idx <= '0;
      sum <= '0;
    end
    if (cmd.shift_write) begin
      idx <= idx_inc;
    end
    if (cmd.sum_step) begin
      if (idx_lt_len) begin
        idx <= idx_inc;
      end
      if (acc_pend) begin
        sum <= sum + NW'(rd_data);
      end
    end
    if (cmd.div_init) begin
      idx <= '0;
      quo <= sum;
      rem <= '0;
    end
    if (cmd.div_step) begin
      idx <= idx_inc;
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? rem_sub[LW-1:0] : rem_sh[LW-1:0];
    end
    if (cmd.avg_apply) begin
      avg       <= quo[SW-1:0];
      avg_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_data.sensitivity         <= level;
      result_data.sensitivity_changed <= (level != level_before);
      result_data.delta_check_on      <= delta;
      result_data.feature_on          <= feature;
      result_data.average             <= avg;
      result_data.average_valid       <= avg_valid;
      result_data.samples_held        <= count;
    end
  end

endmodule

// ----- hdl/windowed_delta_sensitivity_select.sv -----
// ----------------------------------------------------------------------------
// windowed_delta_sensitivity_select
// Adaptive touch sensitivity selector over a sliding window of delta samples.
//
//   channel   kind          transfer on           payload
//   item      valid/ready   valid & ready         req_type .. hand_state
//   result    valid/ready   valid & ready         sensitivity .. samples_held
//   config    APB           psel&penable&pwrite   low, high, window_len
//
// Condition, enable, disable, append and no-op items go from decide
// straight to finish. A window shift reads and then writes each entry in
// turn; an average reads the window one sample per cycle, then runs a
// 21-step bit-serial divider.
// Synchronous reset; no clearing pass. A stalled result holds in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module windowed_delta_sensitivity_select #(
  parameter int WINDOW_MAX = wdss_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  wdss_item_if.sink                    item,
  wdss_result_if.source                result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wdss_pkg::PADDR_W-1:0] paddr,
  input  logic [wdss_pkg::PDATA_W-1:0] pwdata,
  output logic [wdss_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  wdss_pkg::cfg_t  cfg;
  wdss_pkg::cmd_t  cmd;
  wdss_pkg::stat_t stat;

  wdss_cfg #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wdss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wdss_dp #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_data    (item.data),
    .cmd          (cmd),
    .stat         (stat),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .result_data  (result.data)
  );

endmodule
